### hw/rtl/pcs_pkg.sv
package pcs_pkg;

  // Table geometry and field widths
  localparam int NUM_SLOTS = 8;
  localparam int TIME_BITS = 32;
  localparam int SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CMD_W     = 2;
  localparam int IVL_W     = 16;
  localparam int REP_W     = 8;
  localparam int SLOT_IN_W = 3;
  localparam int EV_W      = 3;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SLOT_BITS-1:0] pcs_idx_t;

  localparam pcs_idx_t LAST_IDX = pcs_idx_t'(NUM_SLOTS - 1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

  // Event codes
  localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EV_W-1:0] EV_FIRED   = 3'd1;
  localparam logic [EV_W-1:0] EV_ADDED   = 3'd2;
  localparam logic [EV_W-1:0] EV_FULL    = 3'd3;
  localparam logic [EV_W-1:0] EV_STOPPED = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic            latch;
    logic            tick_adv;
    logic            add_start;
    logic            do_stop;
    logic            scan_clr;
    logic            scan_next;
    logic            do_add;
    logic            do_fire;
    logic            res_set;
    logic [EV_W-1:0] res_ev;
    logic            load_out;
  } pcs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             running;
    logic             slot_ok;
    logic             hit;
    logic             free;
    logic             last;
  } pcs_sts_t;

endpackage

### hw/rtl/pcs_if.sv
interface pcs_in_if;
  logic                             valid;
  logic                             ready;
  logic [pcs_pkg::CMD_W-1:0]        command;
  logic [pcs_pkg::IVL_W-1:0]        interval;
  logic [pcs_pkg::REP_W-1:0]        repeat_count;
  logic [pcs_pkg::SLOT_IN_W-1:0]    slot;

  modport source (output valid, command, interval, repeat_count, slot, input ready);
  modport sink   (input valid, command, interval, repeat_count, slot, output ready);
endinterface

interface pcs_out_if;
  logic                             valid;
  logic                             ready;
  logic [pcs_pkg::EV_W-1:0]         event_res;
  logic [pcs_pkg::SLOT_IN_W-1:0]    slot_out;

  modport source (output valid, event_res, slot_out, input ready);
  modport sink   (input valid, event_res, slot_out, output ready);
endinterface

### hw/rtl/periodic_callback_scheduler_top.sv
// Sequence: accept, dispatch, then for stop, unknown command or halted tick the result is staged
//   from dispatch; tick and add scan the slot table one slot per cycle, visiting 1 to NUM_SLOTS slots;
//   the result then moves to the output register once that register is empty or being read.
// One transaction at a time: no new transaction is taken until the last one's result is loaded.
//   The next transaction is taken while a finished result waits in the output register.
// Reset (rst_n, synchronous): all slots free, time zero and halted, no result pending.
module periodic_callback_scheduler_top (
  input  logic       clk,
  input  logic       rst_n,
  pcs_in_if.sink     in_if,
  pcs_out_if.source  out_if
);

  pcs_pkg::pcs_cmd_t cmd;
  pcs_pkg::pcs_sts_t sts;

  pcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcs_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_command      (in_if.command),
    .in_interval     (in_if.interval),
    .in_repeat_count (in_if.repeat_count),
    .in_slot         (in_if.slot),
    .out_event_res   (out_if.event_res),
    .out_slot_out    (out_if.slot_out)
  );

endmodule

### hw/rtl/pcs_datapath.sv
module pcs_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pcs_pkg::pcs_cmd_t               cmd,
  output pcs_pkg::pcs_sts_t               sts,
  input  logic [pcs_pkg::CMD_W-1:0]       in_command,
  input  logic [pcs_pkg::IVL_W-1:0]       in_interval,
  input  logic [pcs_pkg::REP_W-1:0]       in_repeat_count,
  input  logic [pcs_pkg::SLOT_IN_W-1:0]   in_slot,
  output logic [pcs_pkg::EV_W-1:0]        out_event_res,
  output logic [pcs_pkg::SLOT_IN_W-1:0]   out_slot_out
);

  // Latched transaction fields
  logic [pcs_pkg::CMD_W-1:0]     cmd_r;
  logic [pcs_pkg::IVL_W-1:0]     ivl_r;
  logic [pcs_pkg::REP_W-1:0]     rep_r;
  logic [pcs_pkg::SLOT_IN_W-1:0] slot_r;

  // Scheduler state
  pcs_pkg::time_t                now_r, now_nxt;
  logic                          running_r, running_nxt;
  logic [pcs_pkg::NUM_SLOTS-1:0] active_r, active_nxt;
  pcs_pkg::pcs_idx_t             idx_r, idx_nxt;

  // Slot table
  logic [pcs_pkg::IVL_W-1:0]     slot_ivl_r [pcs_pkg::NUM_SLOTS];
  logic [pcs_pkg::REP_W-1:0]     slot_lim_r [pcs_pkg::NUM_SLOTS];
  logic [pcs_pkg::REP_W-1:0]     slot_cnt_r [pcs_pkg::NUM_SLOTS];
  pcs_pkg::time_t                slot_due_r [pcs_pkg::NUM_SLOTS];

  // Pending and delivered result
  logic [pcs_pkg::EV_W-1:0]      res_ev_r;
  logic [pcs_pkg::SLOT_IN_W-1:0] res_slot_r;
  logic [pcs_pkg::EV_W-1:0]      out_ev_r;
  logic [pcs_pkg::SLOT_IN_W-1:0] out_slot_r;

  logic [pcs_pkg::IVL_W-1:0]     rd_ivl;
  logic [pcs_pkg::REP_W-1:0]     rd_lim;
  logic [pcs_pkg::REP_W-1:0]     rd_cnt;
  pcs_pkg::time_t                rd_due;
  logic                          hit;
  logic                          fire_last;
  pcs_pkg::pcs_idx_t             stop_idx;
  logic [pcs_pkg::SLOT_IN_W-1:0] res_slot_nxt;

  // Read the slot under the scan pointer
  assign rd_ivl = slot_ivl_r[idx_r];
  assign rd_lim = slot_lim_r[idx_r];
  assign rd_cnt = slot_cnt_r[idx_r];
  assign rd_due = slot_due_r[idx_r];

  assign hit = active_r[idx_r] && (rd_due <= now_r) &&
               ((rd_cnt < rd_lim) || (rd_lim == '0));
  assign fire_last = (rd_lim != '0) && (rd_cnt >= rd_lim - 8'd1);
  assign stop_idx  = pcs_pkg::pcs_idx_t'(slot_r);

  // Report status
  always_comb begin
    sts.cmd     = cmd_r;
    sts.running = running_r;
    sts.slot_ok = 32'(slot_r) < 32'(pcs_pkg::NUM_SLOTS);
    sts.hit     = hit;
    sts.free    = !active_r[idx_r];
    sts.last    = (idx_r == pcs_pkg::LAST_IDX);
  end

  // Update time, run flag, slot occupancy and scan pointer
  always_comb begin
    now_nxt     = now_r;
    running_nxt = running_r;
    active_nxt  = active_r;
    idx_nxt     = idx_r;
    if (cmd.tick_adv) begin
      now_nxt = now_r + pcs_pkg::time_t'(1);
    end
    if (cmd.add_start && (active_r == '0)) begin
      running_nxt = 1'b1;
    end
    if (cmd.do_stop) begin
      active_nxt[stop_idx] = 1'b0;
      if (active_nxt == '0) begin
        running_nxt = 1'b0;
      end
    end
    if (cmd.do_add) begin
      active_nxt[idx_r] = 1'b1;
    end
    if (cmd.do_fire && fire_last) begin
      active_nxt[idx_r] = 1'b0;
    end
    if (cmd.scan_clr) begin
      idx_nxt = '0;
    end else if (cmd.scan_next) begin
      idx_nxt = idx_r + pcs_pkg::pcs_idx_t'(1);
    end
  end

  // Pick the slot that goes with the event
  always_comb begin
    if ((cmd.res_ev == pcs_pkg::EV_FIRED) || (cmd.res_ev == pcs_pkg::EV_ADDED)) begin
      res_slot_nxt = 3'(idx_r);
    end else if (cmd.res_ev == pcs_pkg::EV_STOPPED) begin
      res_slot_nxt = slot_r;
    end else begin
      res_slot_nxt = '0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r     <= '0;
      running_r <= 1'b0;
      active_r  <= '0;
      idx_r     <= '0;
    end else begin
      now_r     <= now_nxt;
      running_r <= running_nxt;
      active_r  <= active_nxt;
      idx_r     <= idx_nxt;
    end
  end

  // Capture transaction fields, write slot entries, stage results
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= in_command;
      ivl_r  <= in_interval;
      rep_r  <= in_repeat_count;
      slot_r <= in_slot;
    end
    if (cmd.do_add) begin
      slot_ivl_r[idx_r] <= ivl_r;
      slot_lim_r[idx_r] <= rep_r;
      slot_cnt_r[idx_r] <= '0;
      slot_due_r[idx_r] <= now_r + pcs_pkg::time_t'(ivl_r);
    end
    if (cmd.do_fire) begin
      slot_due_r[idx_r] <= now_r + pcs_pkg::time_t'(rd_ivl);
      if (!fire_last) begin
        slot_cnt_r[idx_r] <= rd_cnt + 8'd1;
      end
    end
    if (cmd.res_set) begin
      res_ev_r   <= cmd.res_ev;
      res_slot_r <= res_slot_nxt;
    end
    if (cmd.load_out) begin
      out_ev_r   <= res_ev_r;
      out_slot_r <= res_slot_r;
    end
  end

  assign out_event_res = out_ev_r;
  assign out_slot_out  = out_slot_r;

`ifndef SYNTH
  a_fire_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_fire |-> hit)
    else $error("slot fired without being due");

  a_add_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_add |-> !active_r[idx_r])
    else $error("add wrote an occupied slot");

  a_busy_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r != '0) |-> running_r)
    else $error("slots active while time is halted");
`endif

endmodule

### hw/rtl/pcs_ctrl.sv
module pcs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pcs_pkg::pcs_sts_t sts,
  output pcs_pkg::pcs_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_TICK,
    S_SCAN_ADD,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequence one transaction: dispatch, scan the table for tick and add, hand off the result
  always_comb begin
    cmd       = '0;
    cmd.res_ev = pcs_pkg::EV_NONE;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.cmd)
          pcs_pkg::CMD_TICK: begin
            if (sts.running) begin
              cmd.tick_adv = 1'b1;
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SCAN_TICK;
            end else begin
              cmd.res_set = 1'b1;
              state_nxt   = S_DONE;
            end
          end
          pcs_pkg::CMD_ADD: begin
            cmd.add_start = 1'b1;
            cmd.scan_clr  = 1'b1;
            state_nxt     = S_SCAN_ADD;
          end
          pcs_pkg::CMD_STOP: begin
            cmd.res_set = 1'b1;
            if (sts.slot_ok) begin
              cmd.do_stop = 1'b1;
              cmd.res_ev  = pcs_pkg::EV_STOPPED;
            end
            state_nxt = S_DONE;
          end
          default: begin
            cmd.res_set = 1'b1;
            state_nxt   = S_DONE;
          end
        endcase
      end
      S_SCAN_TICK: begin
        if (sts.hit) begin
          cmd.do_fire = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_ev  = pcs_pkg::EV_FIRED;
          state_nxt   = S_DONE;
        end else if (sts.last) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_SCAN_ADD: begin
        if (sts.free) begin
          cmd.do_add  = 1'b1;
          cmd.res_set = 1'b1;
          cmd.res_ev  = pcs_pkg::EV_ADDED;
          state_nxt   = S_DONE;
        end else if (sts.last) begin
          cmd.res_set = 1'b1;
          cmd.res_ev  = pcs_pkg::EV_FULL;
          state_nxt   = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold output valid until the result transaction completes
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISPATCH))
    else $error("accepted transaction not dispatched");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule
